[rtl/line_follower_steering_fsm_core_defines.svh]
// Assertion macros shared by the line follower steering core.
`ifndef LINE_FOLLOWER_STEERING_FSM_CORE_DEFINES_SVH
`define LINE_FOLLOWER_STEERING_FSM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle, checked outside reset.
`define LFS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfs: implication check failed");

// Antecedent implies consequent in the next cycle, checked outside reset.
`define LFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfs: next-cycle check failed");

`else

`define LFS_ASSERT_IMP(name, ante, cons)
`define LFS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[rtl/lfs_pkg.sv]
// Types, constants and register indexes of the line follower steering core.
package lfs_pkg;

  // Race phase, one-hot.
  typedef enum logic [4:0] {
    PH_WAIT     = 5'b00001,
    PH_APPROACH = 5'b00010,
    PH_HALT     = 5'b00100,
    PH_TRACK    = 5'b01000,
    PH_FINAL    = 5'b10000
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BLACK_OUTER  = 3'd0,
    REG_BLACK_INNER  = 3'd1,
    REG_WHITE_LEVEL  = 3'd2,
    REG_STOP_BLACK   = 3'd3,
    REG_SLOW_SPEED   = 3'd4,
    REG_FULL_SPEED   = 3'd5,
    REG_TURN_SPEED   = 3'd6,
    REG_HARD_TURN_MS = 3'd7
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] BLACK_OUTER_RST  = 16'd9000;
  localparam logic [15:0] BLACK_INNER_RST  = 16'd16000;
  localparam logic [15:0] WHITE_LEVEL_RST  = 16'd7000;
  localparam logic [15:0] STOP_BLACK_RST   = 16'd8000;
  localparam logic [7:0]  SLOW_SPEED_RST   = 8'd100;
  localparam logic [7:0]  FULL_SPEED_RST   = 8'd200;
  localparam logic [7:0]  TURN_SPEED_RST   = 8'd255;
  localparam logic [7:0]  HARD_TURN_MS_RST = 8'd55;

  // Fixed drive constants.
  localparam logic [7:0] MOVE_MS          = 8'd1;
  localparam logic [7:0] CROSS_MS         = 8'd200;
  localparam logic [7:0] FINAL_CROSS_MS   = 8'd50;
  localparam logic [7:0] FINAL_TURN_SPEED = 8'd100;

  typedef struct packed {
    logic [15:0] black_outer;
    logic [15:0] black_inner;
    logic [15:0] white_level;
    logic [15:0] stop_black;
    logic [7:0]  slow_speed;
    logic [7:0]  full_speed;
    logic [7:0]  turn_speed;
    logic [7:0]  hard_turn_ms;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] left_outer;
    logic [15:0] left_inner;
    logic [15:0] right_inner;
    logic [15:0] right_outer;
  } item_t;

  typedef struct packed {
    logic       motors_on;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       left_reverse;
    logic       right_reverse;
    logic [7:0] duration_ms;
  } res_t;

  // Outcome of one item: whether a drive command is issued, and the new phase.
  typedef struct packed {
    logic   emit;
    phase_t phase_next;
    res_t   res;
  } dec_t;

endpackage

[rtl/lfs_if.sv]
// Handshake interfaces for the sample, drive command and configuration channels.
interface lfs_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] left_outer;
  logic [15:0] left_inner;
  logic [15:0] right_inner;
  logic [15:0] right_outer;

  modport source (output valid, output cmd, output left_outer, output left_inner,
                  output right_inner, output right_outer, input ready);
  modport sink (input valid, input cmd, input left_outer, input left_inner,
                input right_inner, input right_outer, output ready);
endinterface

interface lfs_result_if;
  logic       valid;
  logic       ready;
  logic       motors_on;
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic       left_reverse;
  logic       right_reverse;
  logic [7:0] duration_ms;

  modport source (output valid, output motors_on, output left_speed, output right_speed,
                  output left_reverse, output right_reverse, output duration_ms,
                  input ready);
  modport sink (input valid, input motors_on, input left_speed, input right_speed,
                input left_reverse, input right_reverse, input duration_ms,
                output ready);
endinterface

interface lfs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfs_pkg::CFG_IDX_W-1:0]  index;
  logic [lfs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lfs_steer.sv]
// Sample classification and phase transition logic of the steering core.
module lfs_steer (
  input  lfs_pkg::phase_t phase,
  input  lfs_pkg::cfg_t   cfg,
  input  lfs_pkg::item_t  item,
  output lfs_pkg::dec_t   dec
);

  function automatic lfs_pkg::res_t drive(input logic on, input logic [7:0] ls,
                                          input logic [7:0] rs, input logic lrev,
                                          input logic rrev, input logic [7:0] dur);
    lfs_pkg::res_t r;
    r.motors_on     = on;
    r.left_speed    = ls;
    r.right_speed   = rs;
    r.left_reverse  = lrev;
    r.right_reverse = rrev;
    r.duration_ms   = dur;
    return r;
  endfunction

  logic all_black, all_stop, only_left, only_right;
  logic three_left, three_right, drift_left, drift_right;
  logic lo_gt_bo, ro_gt_bo, li_gt_bi, ri_gt_bi, li_lt_bi, ri_lt_bi;
  logic lo_lt_w, li_lt_w, ri_lt_w, ro_lt_w;
  lfs_pkg::res_t stop_cmd;

  assign lo_gt_bo = item.left_outer > cfg.black_outer;
  assign ro_gt_bo = item.right_outer > cfg.black_outer;
  assign li_gt_bi = item.left_inner > cfg.black_inner;
  assign ri_gt_bi = item.right_inner > cfg.black_inner;
  assign li_lt_bi = item.left_inner < cfg.black_inner;
  assign ri_lt_bi = item.right_inner < cfg.black_inner;
  assign lo_lt_w  = item.left_outer < cfg.white_level;
  assign li_lt_w  = item.left_inner < cfg.white_level;
  assign ri_lt_w  = item.right_inner < cfg.white_level;
  assign ro_lt_w  = item.right_outer < cfg.white_level;

  assign all_black   = lo_gt_bo && li_gt_bi && ri_gt_bi && ro_gt_bo;
  assign all_stop    = (item.left_outer > cfg.stop_black) && (item.left_inner > cfg.stop_black)
                    && (item.right_inner > cfg.stop_black)
                    && (item.right_outer > cfg.stop_black);
  assign only_left   = lo_gt_bo && li_lt_w && ri_lt_w && ro_lt_w;
  assign only_right  = lo_lt_w && li_lt_w && ri_lt_w && ro_gt_bo;
  assign three_left  = lo_gt_bo && li_gt_bi && ri_gt_bi && ro_lt_w;
  assign three_right = lo_lt_w && li_gt_bi && ri_gt_bi && ro_gt_bo;
  assign drift_left  = li_gt_bi && ri_lt_bi;
  assign drift_right = li_lt_bi && ri_gt_bi;

  assign stop_cmd = drive(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0);

  always_comb begin
    dec.emit       = 1'b0;
    dec.phase_next = phase;
    dec.res        = stop_cmd;
    case (phase)
      lfs_pkg::PH_WAIT: begin
        if (item.cmd == lfs_pkg::CMD_START) begin
          dec.phase_next = lfs_pkg::PH_APPROACH;
        end
      end
      lfs_pkg::PH_APPROACH: begin
        if (item.cmd == lfs_pkg::CMD_SAMPLE) begin
          dec.emit = 1'b1;
          if (all_black) begin
            dec.phase_next = lfs_pkg::PH_HALT;
          end else if (drift_left) begin
            dec.res = drive(1'b1, 8'd0, cfg.turn_speed, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          end else if (drift_right) begin
            dec.res = drive(1'b1, cfg.turn_speed, 8'd0, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          end else begin
            dec.res = drive(1'b1, cfg.slow_speed, cfg.slow_speed, 1'b0, 1'b0,
                            lfs_pkg::MOVE_MS);
          end
        end
      end
      lfs_pkg::PH_HALT: begin
        if (item.cmd == lfs_pkg::CMD_START) begin
          dec.emit       = 1'b1;
          dec.phase_next = lfs_pkg::PH_TRACK;
          dec.res        = drive(1'b1, cfg.full_speed, cfg.full_speed, 1'b0, 1'b0,
                                 lfs_pkg::CROSS_MS);
        end
      end
      lfs_pkg::PH_TRACK: begin
        if (item.cmd == lfs_pkg::CMD_SAMPLE) begin
          dec.emit = 1'b1;
          if (all_stop) begin
            dec.phase_next = lfs_pkg::PH_FINAL;
            dec.res = drive(1'b1, cfg.full_speed, cfg.full_speed, 1'b0, 1'b0,
                            lfs_pkg::FINAL_CROSS_MS);
          end else if (only_left) begin
            dec.res = drive(1'b1, cfg.turn_speed, cfg.turn_speed, 1'b1, 1'b0,
                            cfg.hard_turn_ms);
          end else if (only_right) begin
            dec.res = drive(1'b1, cfg.turn_speed, cfg.turn_speed, 1'b0, 1'b1,
                            cfg.hard_turn_ms);
          end else if (three_left) begin
            dec.res = drive(1'b1, cfg.turn_speed, cfg.turn_speed, 1'b1, 1'b0,
                            lfs_pkg::MOVE_MS);
          end else if (three_right) begin
            dec.res = drive(1'b1, cfg.turn_speed, cfg.turn_speed, 1'b0, 1'b1,
                            lfs_pkg::MOVE_MS);
          end else if (drift_left) begin
            dec.res = drive(1'b1, 8'd0, cfg.turn_speed, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          end else if (drift_right) begin
            dec.res = drive(1'b1, cfg.turn_speed, 8'd0, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          end else begin
            dec.res = drive(1'b1, cfg.full_speed, cfg.full_speed, 1'b0, 1'b0,
                            lfs_pkg::MOVE_MS);
          end
        end
      end
      lfs_pkg::PH_FINAL: begin
        if (item.cmd == lfs_pkg::CMD_SAMPLE) begin
          dec.emit = 1'b1;
          if (all_stop) begin
            dec.res = stop_cmd;
          end else if (three_left || (!three_right && drift_left)) begin
            dec.res = drive(1'b1, 8'd0, lfs_pkg::FINAL_TURN_SPEED, 1'b0, 1'b0,
                            lfs_pkg::MOVE_MS);
          end else if (three_right || drift_right) begin
            dec.res = drive(1'b1, lfs_pkg::FINAL_TURN_SPEED, 8'd0, 1'b0, 1'b0,
                            lfs_pkg::MOVE_MS);
          end else begin
            dec.res = drive(1'b1, cfg.full_speed, cfg.full_speed, 1'b0, 1'b0,
                            lfs_pkg::MOVE_MS);
          end
        end
      end
      default: begin
        dec.emit = 1'b0;
      end
    endcase
  end

endmodule

[rtl/line_follower_steering_fsm_core.sv]
// Top level of the line follower steering core: handshakes, registers and phase.
// The core takes one transaction per clock cycle, either a start-signal event or a
// four-sensor reflectance sample, and answers with at most one drive command. An
// accepted transaction is held in an input register while a bank of parallel
// threshold comparators and the race phase decide the drive command; the command
// then sits in a result register until the downstream side takes it. The sustained
// rate is one transaction per cycle: the result register decouples the two sides,
// and the input side only stalls when the held item yields a command while the
// result register is still full and not being taken that cycle. Events the current
// phase ignores (a start while running, a sample while waiting or stopped) advance
// without producing a result. Configuration writes are taken in any cycle, but must
// only be issued while the core is idle; the race phase resets to waiting for start.
`include "line_follower_steering_fsm_core_defines.svh"

module line_follower_steering_fsm_core (
  input logic           clk,
  input logic           rst,
  lfs_item_if.sink      item,
  lfs_result_if.source  result,
  lfs_cfg_if.sink       cfg
);

  // Configuration registers.
  lfs_pkg::cfg_t cfg_q;

  // Input stage: the accepted transaction waiting for its decision.
  logic           held_valid;
  lfs_pkg::item_t held;

  // Race phase and the decision for the held transaction.
  lfs_pkg::phase_t phase;
  lfs_pkg::dec_t   dec;

  // Result register.
  logic          res_valid;
  lfs_pkg::res_t res_q;

  logic advance;
  logic item_take;

  // The held transaction moves on when it yields no command, or when the result
  // register is free or is being emptied in this cycle.
  assign advance   = held_valid && (!dec.emit || !res_valid || result.ready);
  assign item.ready = !held_valid || advance;
  assign item_take = item.valid && item.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.black_outer  <= lfs_pkg::BLACK_OUTER_RST;
      cfg_q.black_inner  <= lfs_pkg::BLACK_INNER_RST;
      cfg_q.white_level  <= lfs_pkg::WHITE_LEVEL_RST;
      cfg_q.stop_black   <= lfs_pkg::STOP_BLACK_RST;
      cfg_q.slow_speed   <= lfs_pkg::SLOW_SPEED_RST;
      cfg_q.full_speed   <= lfs_pkg::FULL_SPEED_RST;
      cfg_q.turn_speed   <= lfs_pkg::TURN_SPEED_RST;
      cfg_q.hard_turn_ms <= lfs_pkg::HARD_TURN_MS_RST;
    end else if (cfg.valid) begin
      case (lfs_pkg::reg_idx_t'(cfg.index))
        lfs_pkg::REG_BLACK_OUTER:  cfg_q.black_outer  <= cfg.data;
        lfs_pkg::REG_BLACK_INNER:  cfg_q.black_inner  <= cfg.data;
        lfs_pkg::REG_WHITE_LEVEL:  cfg_q.white_level  <= cfg.data;
        lfs_pkg::REG_STOP_BLACK:   cfg_q.stop_black   <= cfg.data;
        lfs_pkg::REG_SLOW_SPEED:   cfg_q.slow_speed   <= cfg.data[7:0];
        lfs_pkg::REG_FULL_SPEED:   cfg_q.full_speed   <= cfg.data[7:0];
        lfs_pkg::REG_TURN_SPEED:   cfg_q.turn_speed   <= cfg.data[7:0];
        lfs_pkg::REG_HARD_TURN_MS: cfg_q.hard_turn_ms <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register. The payload needs no reset; only its valid flag does.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      held.cmd         <= item.cmd;
      held.left_outer  <= item.left_outer;
      held.left_inner  <= item.left_inner;
      held.right_inner <= item.right_inner;
      held.right_outer <= item.right_outer;
    end
  end

  lfs_steer u_steer (
    .phase (phase),
    .cfg   (cfg_q),
    .item  (held),
    .dec   (dec)
  );

  // The phase changes only when the held transaction is retired, so the next
  // transaction in the input register always sees the phase its predecessor left.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lfs_pkg::PH_WAIT;
    end else if (advance) begin
      phase <= dec.phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && dec.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.emit) begin
      res_q <= dec.res;
    end
  end

  assign result.valid         = res_valid;
  assign result.motors_on     = res_q.motors_on;
  assign result.left_speed    = res_q.left_speed;
  assign result.right_speed   = res_q.right_speed;
  assign result.left_reverse  = res_q.left_reverse;
  assign result.right_reverse = res_q.right_reverse;
  assign result.duration_ms   = res_q.duration_ms;

  // Once the final run has begun the phase never changes again.
  `LFS_ASSERT_NEXT(a_final_sticks, phase == lfs_pkg::PH_FINAL, phase == lfs_pkg::PH_FINAL)

  // A start retired while stopped always enters line tracking.
  `LFS_ASSERT_NEXT(a_halt_to_track,
    advance && held.cmd == lfs_pkg::CMD_START && phase == lfs_pkg::PH_HALT,
    phase == lfs_pkg::PH_TRACK && res_valid)

  // A stopped-motor command carries no speed and no duration.
  `LFS_ASSERT_IMP(a_stop_is_quiet, res_valid && !res_q.motors_on,
    res_q.left_speed == 8'd0 && res_q.right_speed == 8'd0 && res_q.duration_ms == 8'd0)

  // A held transaction that cannot retire stays in the input register unchanged.
  `LFS_ASSERT_NEXT(a_held_stays, held_valid && !advance, held_valid && $stable(held))

endmodule

[test/tb_line_follower_steering_fsm_core.sv]
// Self-checking testbench for the line follower steering core, with a race-phase predictor.
module tb_line_follower_steering_fsm_core;
  timeunit 1ns;
  timeprecision 1ps;

  // A quiet stretch longer than this means the core has hung. The longest legitimate
  // one is the receiver hold-off below, plus a long sender gap and a stall word.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Time from acceptance to a result being offered, with some margin. An ignored
  // event gives no result, so this is also the time an item may still be in flight.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PRINT_CAP = 40;

  // Register settings that the run goes through.
  typedef enum int {SET_RESET, SET_TOP, SET_ZERO, SET_RANDOM, SET_REALISTIC} setting_t;
  // Shapes of a random sensor reading, relative to the current thresholds.
  typedef enum int {
    RD_WHITE, RD_BLACK, RD_AT_BLACK, RD_AT_WHITE, RD_NEAR_STOP, RD_RAIL, RD_ANY
  } reading_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfs_item_if   item_bus ();
  lfs_result_if res_bus ();
  lfs_cfg_if    cfg_bus ();

  line_follower_steering_fsm_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Thresholds and speeds as the core should hold them. They only change while the
  // core is idle, so the stimulus side and the predictor can share one copy.
  lfs_pkg::cfg_t thr = '{
    black_outer:  lfs_pkg::BLACK_OUTER_RST,
    black_inner:  lfs_pkg::BLACK_INNER_RST,
    white_level:  lfs_pkg::WHITE_LEVEL_RST,
    stop_black:   lfs_pkg::STOP_BLACK_RST,
    slow_speed:   lfs_pkg::SLOW_SPEED_RST,
    full_speed:   lfs_pkg::FULL_SPEED_RST,
    turn_speed:   lfs_pkg::TURN_SPEED_RST,
    hard_turn_ms: lfs_pkg::HARD_TURN_MS_RST
  };

  // The race phase as seen by the predictor at each accepted transaction, and the
  // phase the stimulus generator expects once everything queued so far is taken.
  lfs_pkg::phase_t race_state = lfs_pkg::PH_WAIT;
  lfs_pkg::phase_t plan_phase = lfs_pkg::PH_WAIT;

  lfs_pkg::item_t sample_queue [$];
  lfs_pkg::res_t  drive_expected [$];
  int unsigned issued = 0;
  int unsigned accepted = 0;
  int unsigned fail_count = 0;

  bit          sender_steady = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  function automatic lfs_pkg::res_t drive_word(input logic on, input logic [7:0] ls,
                                               input logic [7:0] rs, input logic lrev,
                                               input logic rrev, input logic [7:0] dur);
    return {on, ls, rs, lrev, rrev, dur};
  endfunction

  // The steering decision for one transaction in a given phase and setting. It has
  // no side effects: it returns whether a drive command results, the command itself
  // and the phase that follows.
  function automatic bit steer_decision(input lfs_pkg::item_t it, input lfs_pkg::cfg_t c,
                                        input lfs_pkg::phase_t ph,
                                        output lfs_pkg::phase_t ph_next,
                                        output lfs_pkg::res_t word);
    logic [15:0] lo, li, ri, ro;
    logic all_black, all_stop, only_left, only_right;
    logic three_left, three_right, drift_left, drift_right;
    bit emits;
    lo = it.left_outer;
    li = it.left_inner;
    ri = it.right_inner;
    ro = it.right_outer;
    // Every comparison is strict, so a reading equal to a threshold is neither side.
    all_black   = lo > c.black_outer && li > c.black_inner &&
                  ri > c.black_inner && ro > c.black_outer;
    all_stop    = lo > c.stop_black && li > c.stop_black &&
                  ri > c.stop_black && ro > c.stop_black;
    only_left   = lo > c.black_outer && li < c.white_level &&
                  ri < c.white_level && ro < c.white_level;
    only_right  = lo < c.white_level && li < c.white_level &&
                  ri < c.white_level && ro > c.black_outer;
    three_left  = lo > c.black_outer && li > c.black_inner &&
                  ri > c.black_inner && ro < c.white_level;
    three_right = lo < c.white_level && li > c.black_inner &&
                  ri > c.black_inner && ro > c.black_outer;
    drift_left  = li > c.black_inner && ri < c.black_inner;
    drift_right = li < c.black_inner && ri > c.black_inner;
    ph_next = ph;
    word = '0;
    emits = 1'b0;
    if (it.cmd == lfs_pkg::CMD_START) begin
      if (ph == lfs_pkg::PH_WAIT) begin
        ph_next = lfs_pkg::PH_APPROACH;
      end else if (ph == lfs_pkg::PH_HALT) begin
        ph_next = lfs_pkg::PH_TRACK;
        word = drive_word(1'b1, c.full_speed, c.full_speed, 1'b0, 1'b0,
                          lfs_pkg::CROSS_MS);
        emits = 1'b1;
      end
    end else begin
      emits = 1'b1;
      case (ph)
        lfs_pkg::PH_APPROACH: begin
          // A stop command is all zeros, motors off.
          if (all_black) ph_next = lfs_pkg::PH_HALT;
          else if (drift_left)
            word = drive_word(1'b1, 8'd0, c.turn_speed, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          else if (drift_right)
            word = drive_word(1'b1, c.turn_speed, 8'd0, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          else
            word = drive_word(1'b1, c.slow_speed, c.slow_speed, 1'b0, 1'b0,
                              lfs_pkg::MOVE_MS);
        end
        lfs_pkg::PH_TRACK: begin
          if (all_stop) begin
            ph_next = lfs_pkg::PH_FINAL;
            word = drive_word(1'b1, c.full_speed, c.full_speed, 1'b0, 1'b0,
                              lfs_pkg::FINAL_CROSS_MS);
          end else if (only_left)
            word = drive_word(1'b1, c.turn_speed, c.turn_speed, 1'b1, 1'b0,
                              c.hard_turn_ms);
          else if (only_right)
            word = drive_word(1'b1, c.turn_speed, c.turn_speed, 1'b0, 1'b1,
                              c.hard_turn_ms);
          else if (three_left)
            word = drive_word(1'b1, c.turn_speed, c.turn_speed, 1'b1, 1'b0,
                              lfs_pkg::MOVE_MS);
          else if (three_right)
            word = drive_word(1'b1, c.turn_speed, c.turn_speed, 1'b0, 1'b1,
                              lfs_pkg::MOVE_MS);
          else if (drift_left)
            word = drive_word(1'b1, 8'd0, c.turn_speed, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          else if (drift_right)
            word = drive_word(1'b1, c.turn_speed, 8'd0, 1'b0, 1'b0, lfs_pkg::MOVE_MS);
          else
            word = drive_word(1'b1, c.full_speed, c.full_speed, 1'b0, 1'b0,
                              lfs_pkg::MOVE_MS);
        end
        lfs_pkg::PH_FINAL: begin
          // A crossing in the final run stops the robot but the phase stays put.
          if (all_stop) word = '0;
          else if (three_left || (!three_right && drift_left))
            word = drive_word(1'b1, 8'd0, lfs_pkg::FINAL_TURN_SPEED, 1'b0, 1'b0,
                              lfs_pkg::MOVE_MS);
          else if (three_right || drift_right)
            word = drive_word(1'b1, lfs_pkg::FINAL_TURN_SPEED, 8'd0, 1'b0, 1'b0,
                              lfs_pkg::MOVE_MS);
          else
            word = drive_word(1'b1, c.full_speed, c.full_speed, 1'b0, 1'b0,
                              lfs_pkg::MOVE_MS);
        end
        default: emits = 1'b0;
      endcase
    end
    return emits;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("[%0t] drive command error, %s: got %0h, expected %0h", $time, what, seen,
               want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic lfs_pkg::item_t sample(input logic [15:0] lo, input logic [15:0] li,
                                            input logic [15:0] ri, input logic [15:0] ro);
    return {lfs_pkg::CMD_SAMPLE, lo, li, ri, ro};
  endfunction

  // A start event carries sensor readings too; the core must ignore them.
  function automatic lfs_pkg::item_t start_event();
    lfs_pkg::item_t it;
    it.cmd = lfs_pkg::CMD_START;
    it.left_outer = 16'($urandom);
    it.left_inner = 16'($urandom);
    it.right_inner = 16'($urandom);
    it.right_outer = 16'($urandom);
    return it;
  endfunction

  // One reading of the requested shape, where black_th is the black threshold of the
  // sensor in question. Thresholds at the rails fall back to the nearest legal value.
  function automatic logic [15:0] pick_reading(input logic [15:0] black_th,
                                               input reading_kind_t kind);
    logic [15:0] v;
    case (kind)
      RD_WHITE:     v = (thr.white_level == 16'd0) ? 16'd0 :
                        16'($urandom_range(0, thr.white_level - 1));
      RD_BLACK:     v = (black_th == 16'hFFFF) ? 16'hFFFF :
                        16'($urandom_range(black_th + 1, 32'hFFFF));
      RD_AT_BLACK:  v = black_th;
      RD_AT_WHITE:  v = thr.white_level;
      RD_NEAR_STOP: v = thr.stop_black + 16'($urandom_range(0, 2)) - 16'd1;
      RD_RAIL:      v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:      v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Half the samples are clean black/white patterns, so that every four-sensor shape
  // turns up often; the rest mix threshold-hugging and arbitrary readings per sensor.
  function automatic lfs_pkg::item_t random_sample();
    lfs_pkg::item_t it;
    logic [3:0] mask;
    it.cmd = lfs_pkg::CMD_SAMPLE;
    if ($urandom_range(0, 1)) begin
      mask = 4'($urandom_range(0, 15));
      it.left_outer  = pick_reading(thr.black_outer, mask[3] ? RD_BLACK : RD_WHITE);
      it.left_inner  = pick_reading(thr.black_inner, mask[2] ? RD_BLACK : RD_WHITE);
      it.right_inner = pick_reading(thr.black_inner, mask[1] ? RD_BLACK : RD_WHITE);
      it.right_outer = pick_reading(thr.black_outer, mask[0] ? RD_BLACK : RD_WHITE);
    end else begin
      it.left_outer  = pick_reading(thr.black_outer, reading_kind_t'($urandom_range(0, 6)));
      it.left_inner  = pick_reading(thr.black_inner, reading_kind_t'($urandom_range(0, 6)));
      it.right_inner = pick_reading(thr.black_inner, reading_kind_t'($urandom_range(0, 6)));
      it.right_outer = pick_reading(thr.black_outer, reading_kind_t'($urandom_range(0, 6)));
    end
    return it;
  endfunction

  task automatic push_item(input lfs_pkg::item_t it);
    lfs_pkg::phase_t nxt;
    lfs_pkg::res_t word;
    void'(steer_decision(it, thr, plan_phase, nxt, word));
    plan_phase = nxt;
    sample_queue.push_back(it);
    issued++;
  endtask

  // Random samples for the current phase, with the odd stray start event mixed in.
  // A sample that would move the race on is defused by clearing the left outer
  // reading, since neither a crossing nor an all-black line can then be seen.
  task automatic queue_run(input int unsigned n);
    int unsigned done;
    lfs_pkg::item_t it;
    lfs_pkg::phase_t nxt;
    lfs_pkg::res_t word;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 24) == 0) begin
        push_item(start_event());
      end else begin
        it = random_sample();
        void'(steer_decision(it, thr, plan_phase, nxt, word));
        if (nxt != plan_phase) it.left_outer = 16'd0;
        push_item(it);
        done++;
      end
    end
  endtask

  // Waits until every queued transaction has been taken and every drive command has
  // come out, then gives the last item time to leave the pipeline.
  task automatic wait_drained();
    do @(posedge clk); while (accepted != issued || drive_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge with the core idle. Valid is left high so that writes can
  // follow back to back; the caller lowers it after the last one.
  task automatic write_reg(input lfs_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      lfs_pkg::REG_BLACK_OUTER:  thr.black_outer  = val;
      lfs_pkg::REG_BLACK_INNER:  thr.black_inner  = val;
      lfs_pkg::REG_WHITE_LEVEL:  thr.white_level  = val;
      lfs_pkg::REG_STOP_BLACK:   thr.stop_black   = val;
      lfs_pkg::REG_SLOW_SPEED:   thr.slow_speed   = val[7:0];
      lfs_pkg::REG_FULL_SPEED:   thr.full_speed   = val[7:0];
      lfs_pkg::REG_TURN_SPEED:   thr.turn_speed   = val[7:0];
      lfs_pkg::REG_HARD_TURN_MS: thr.hard_turn_ms = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input setting_t s);
    logic [15:0] vals [8];
    int unsigned wl;
    for (int i = 0; i < 8; i++) begin
      case (s)
        SET_TOP:  vals[3'(i)] = 16'hFFFF;
        SET_ZERO: vals[3'(i)] = 16'h0000;
        // The upper byte of an 8-bit register's data is random here and must be dropped.
        default:  vals[3'(i)] = 16'($urandom);
      endcase
    end
    if (s == SET_RESET) begin
      vals[lfs_pkg::REG_BLACK_OUTER]  = lfs_pkg::BLACK_OUTER_RST;
      vals[lfs_pkg::REG_BLACK_INNER]  = lfs_pkg::BLACK_INNER_RST;
      vals[lfs_pkg::REG_WHITE_LEVEL]  = lfs_pkg::WHITE_LEVEL_RST;
      vals[lfs_pkg::REG_STOP_BLACK]   = lfs_pkg::STOP_BLACK_RST;
      vals[lfs_pkg::REG_SLOW_SPEED]   = {8'd0, lfs_pkg::SLOW_SPEED_RST};
      vals[lfs_pkg::REG_FULL_SPEED]   = {8'd0, lfs_pkg::FULL_SPEED_RST};
      vals[lfs_pkg::REG_TURN_SPEED]   = {8'd0, lfs_pkg::TURN_SPEED_RST};
      vals[lfs_pkg::REG_HARD_TURN_MS] = {8'd0, lfs_pkg::HARD_TURN_MS_RST};
    end else if (s == SET_REALISTIC) begin
      // White at or below both black thresholds, as on a real track.
      wl = $urandom_range(500, 12000);
      vals[lfs_pkg::REG_WHITE_LEVEL]  = 16'(wl);
      vals[lfs_pkg::REG_BLACK_OUTER]  = 16'(wl + $urandom_range(0, 8000));
      vals[lfs_pkg::REG_BLACK_INNER]  = 16'(wl + $urandom_range(0, 20000));
      vals[lfs_pkg::REG_STOP_BLACK]   = 16'($urandom_range(2000, 30000));
      vals[lfs_pkg::REG_SLOW_SPEED]   = 16'($urandom_range(0, 255));
      vals[lfs_pkg::REG_FULL_SPEED]   = 16'($urandom_range(0, 255));
      vals[lfs_pkg::REG_TURN_SPEED]   = 16'($urandom_range(0, 255));
      vals[lfs_pkg::REG_HARD_TURN_MS] = 16'($urandom_range(0, 255));
    end
    for (int i = 0; i < 8; i++) write_reg(lfs_pkg::reg_idx_t'(i), vals[3'(i)]);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_setting(input setting_t s, input int unsigned n);
    load_setting(s);
    queue_run(n);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sender. It takes items from the pending queue in bursts of random length with
  // random gaps between them; valid stays high on an item until it is taken. Each
  // accepted transaction goes through the predictor at once, so the expected drive
  // command is queued before the core can possibly produce it.
  // ---------------------------------------------------------------------------
  lfs_pkg::item_t cur_item;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;

  always @(posedge clk) begin : sender
    lfs_pkg::phase_t nxt;
    lfs_pkg::res_t word;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        if (steer_decision(cur_item, thr, race_state, nxt, word))
          drive_expected.push_back(word);
        race_state = nxt;
        accepted++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (gap_left != 0 && !sender_steady) begin
          gap_left--;
          item_bus.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          cur_item = sample_queue.pop_front();
          item_bus.cmd         <= cur_item.cmd;
          item_bus.left_outer  <= cur_item.left_outer;
          item_bus.left_inner  <= cur_item.left_inner;
          item_bus.right_inner <= cur_item.right_inner;
          item_bus.right_outer <= cur_item.right_outer;
          item_bus.valid       <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(10, 40);
              default: gap_left = $urandom_range(1, 5);
            endcase
          end
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off. Each request holds ready low for a long stretch, so that the
  // result register fills and the core has to stall its input side.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hold_off
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker. Ready follows a 16-bit stall word, redrawn each time it
  // runs out: sometimes all ones, sometimes light, sometimes heavy stalling. Every
  // drive command taken is compared field by field with the oldest expectation.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_word = 16'hFFFF;
  logic [3:0]  stall_pos = 4'd0;

  always @(posedge clk) begin : receiver
    lfs_pkg::res_t seen;
    lfs_pkg::res_t want;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        seen = {res_bus.motors_on, res_bus.left_speed, res_bus.right_speed,
                res_bus.left_reverse, res_bus.right_reverse, res_bus.duration_ms};
        if (drive_expected.size() == 0) begin
          report_mismatch("unexpected command", 32'(seen), 32'd0);
        end else begin
          want = drive_expected.pop_front();
          if (seen.motors_on !== want.motors_on)
            report_mismatch("motors_on", 32'(seen.motors_on), 32'(want.motors_on));
          if (seen.left_speed !== want.left_speed)
            report_mismatch("left_speed", 32'(seen.left_speed), 32'(want.left_speed));
          if (seen.right_speed !== want.right_speed)
            report_mismatch("right_speed", 32'(seen.right_speed), 32'(want.right_speed));
          if (seen.left_reverse !== want.left_reverse)
            report_mismatch("left_reverse", 32'(seen.left_reverse),
                            32'(want.left_reverse));
          if (seen.right_reverse !== want.right_reverse)
            report_mismatch("right_reverse", 32'(seen.right_reverse),
                            32'(want.right_reverse));
          if (seen.duration_ms !== want.duration_ms)
            report_mismatch("duration_ms", 32'(seen.duration_ms), 32'(want.duration_ms));
        end
      end
      if (stall_pos == 4'd0) begin
        case ($urandom_range(0, 3))
          0:       stall_word = 16'hFFFF;
          1:       stall_word = 16'($urandom);
          default: stall_word = 16'($urandom | $urandom);
        endcase
      end
      res_bus.ready <= (hold_left == 0) && stall_word[stall_pos];
      stall_pos = stall_pos + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles with no transaction on any channel.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("line_follower_steering_fsm_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence. The race can only run once, since the final phase is never left,
  // so the sequence walks through the phases in order and spends its random traffic,
  // under several register settings, in the approach, tracking and final phases.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    item_bus.valid       = 1'b0;
    item_bus.cmd         = lfs_pkg::CMD_SAMPLE;
    item_bus.left_outer  = 16'd0;
    item_bus.left_inner  = 16'd0;
    item_bus.right_inner = 16'd0;
    item_bus.right_outer = 16'd0;
    res_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = lfs_pkg::REG_BLACK_OUTER;
    cfg_bus.data         = 16'd0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Waiting for start: a sample is ignored, a start moves on with no command.
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(start_event());
    // Approach at the reset thresholds: forward, both pivots, readings exactly on the
    // inner threshold, outer readings on their threshold, and a stray start.
    push_item(sample(16'd0, 16'd0, 16'd0, 16'd0));
    push_item(sample(16'd0, 16'hFFFF, 16'd0, 16'd0));
    push_item(sample(16'd0, 16'd0, 16'hFFFF, 16'd0));
    push_item(sample(16'd0, 16'd16000, 16'd16000, 16'd0));
    push_item(sample(16'd0, 16'd16001, 16'd16000, 16'd0));
    push_item(sample(16'd9000, 16'hFFFF, 16'hFFFF, 16'd9000));
    push_item(start_event());
    queue_run(200);
    wait_drained();

    run_setting(SET_TOP, 100);
    run_setting(SET_ZERO, 100);
    run_setting(SET_RANDOM, 100);

    // Back to the reset values, written explicitly, for the crossings.
    load_setting(SET_RESET);
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Stopped: a sample is ignored, the second start sets off at full speed.
    push_item(sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    push_item(start_event());
    // Tracking: the outer-only and three-sensor tank turns, both pivots, readings on
    // the white level, an outer reading on its threshold, and a stray start.
    push_item(sample(16'hFFFF, 16'd0, 16'd0, 16'd0));
    push_item(sample(16'd0, 16'd0, 16'd0, 16'hFFFF));
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
    push_item(sample(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(sample(16'd7999, 16'hFFFF, 16'd0, 16'd7999));
    push_item(sample(16'd7999, 16'd0, 16'hFFFF, 16'd7999));
    push_item(sample(16'd7000, 16'd7000, 16'd7000, 16'd7000));
    push_item(sample(16'd9000, 16'd0, 16'd0, 16'd0));
    push_item(start_event());
    queue_run(100);
    wait_drained();

    // Hold the receiver off while the sender keeps offering samples that all give
    // commands, so that the core backs up and stalls its input.
    sender_steady = 1'b1;
    hold_requests++;
    queue_run(200);
    wait_drained();
    sender_steady = 1'b0;

    run_setting(SET_RANDOM, 150);
    run_setting(SET_ZERO, 100);
    run_setting(SET_TOP, 100);
    run_setting(SET_REALISTIC, 150);

    // The crossing into the final run, then the final-run steering and its stop.
    load_setting(SET_RESET);
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
    push_item(sample(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_item(sample(16'd0, 16'hFFFF, 16'd0, 16'd0));
    push_item(sample(16'd0, 16'd0, 16'hFFFF, 16'd0));
    push_item(sample(16'd0, 16'd0, 16'd0, 16'd0));
    push_item(sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_run(150);
    wait_drained();

    run_setting(SET_RANDOM, 100);
    run_setting(SET_TOP, 50);
    run_setting(SET_ZERO, 50);
    run_setting(SET_REALISTIC, 100);

    if (drive_expected.size() != 0)
      report_mismatch("commands never delivered", 32'(drive_expected.size()), 32'd0);
    if (fail_count == 0)
      $display("line_follower_steering_fsm_core verification clean");
    else
      $display("line_follower_steering_fsm_core verification failed");
    $finish;
  end

endmodule
